@@ rtl/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger core.
// No dependencies; imported by ultrasonic_echo_ranger_core.
package uer_pkg;

   // Field widths
   localparam int TRIG_W  = 8;
   localparam int TICK_W  = 16;
   localparam int DIST_W  = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Register reset values
   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST  = 8'd10;
   localparam logic [TICK_W-1:0] MAX_WAIT_TICKS_RST = 16'd30000;
   localparam logic [TICK_W-1:0] CLAMP_TICKS_RST    = 16'd17400;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WAIT_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_TICKS    = 2'd2;

   // Distance = (len*16 + 29) / 58, done as (x * RECIP) >> RECIP_SHIFT.
   // x stays below 2^21, and 14 * x < 2^27 keeps the quotient exact.
   localparam int DIV_IN_W    = 21;
   localparam int RECIP_W     = 22;
   localparam int PROD_W      = DIV_IN_W + RECIP_W;
   localparam int RECIP_SHIFT = 27;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2314099;
   localparam logic [DIV_IN_W-1:0] ROUND_ADD = 21'd29;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // Result flags that travel together into the result register
   typedef struct packed {
      logic trigger;
      logic busy;
      logic done;
      logic timed_out;
   } rsp_flags_type;

endpackage

@@ rtl/ultrasonic_echo_ranger_core.sv @@
// Ultrasonic echo ranger: trigger, echo timing and distance in one stage.
// Depends on uer_pkg.
//
// One request transfer is one microsecond tick (echo pin sample plus an
// optional start request in tuser); every tick yields exactly one response
// transfer carrying the trigger pin level, busy, a one-tick done pulse and
// the held timeout flag, echo length and distance in 1/16 cm. The core takes
// one tick per clock cycle unless the response side stalls; a tick goes
// through the request register, then the result register. The path between
// them is the phase/counter update plus one 21 x 22 bit reciprocal multiply
// for the divide by 58. Configuration writes take effect on the next edge.
module ultrasonic_echo_ranger_core
   import uer_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] echo_level, [7:1] zero
   input  logic                  req_tuser,   // [0] action (start request)
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] trigger_level, [1] busy_res, [2] done_res, [3] timed_out,
   // [19:4] echo_ticks, [34:20] distance_sixteenths, [39:35] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   // Configuration registers
   logic [TRIG_W-1:0] trigger_ticks_ff;
   logic [TICK_W-1:0] max_wait_ticks_ff;
   logic [TICK_W-1:0] clamp_ticks_ff;

   // Request register
   logic in_valid_ff;
   logic in_start_ff;
   logic in_echo_ff;

   // Measurement state
   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic              prev_echo_ff;
   logic [TICK_W-1:0] held_ticks_ff, held_ticks_in;
   logic [DIST_W-1:0] held_dist_ff, held_dist_in;
   logic              held_timeout_ff, held_timeout_in;

   // Result register
   logic              rsp_valid_ff;
   rsp_flags_type     rsp_flags_ff, rsp_flags_in;
   logic [TICK_W-1:0] rsp_ticks_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   logic                advance;
   logic                finish;
   logic                finish_timeout;
   logic [TICK_W-1:0]   finish_len;
   logic [DIV_IN_W-1:0] div_in;
   logic [PROD_W-1:0]   div_prod;

   // Move a tick on when the result slot is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff  <= TRIGGER_TICKS_RST;
         max_wait_ticks_ff <= MAX_WAIT_TICKS_RST;
         clamp_ticks_ff    <= CLAMP_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER_TICKS:  trigger_ticks_ff  <= csr_wdata[TRIG_W-1:0];
            CSR_MAX_WAIT_TICKS: max_wait_ticks_ff <= csr_wdata;
            CSR_CLAMP_TICKS:    clamp_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture request transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_start_ff <= req_tuser;
         in_echo_ff  <= req_tdata[0];
      end
   end

   // Phase and tick counter update for one tick
   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      finish         = 1'b0;
      finish_timeout = 1'b0;
      finish_len     = tick_count_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (in_start_ff) begin
               phase_in      = PH_TRIG;
               tick_count_in = TICK_W'(1);
            end
         end
         PH_TRIG: begin
            if (tick_count_ff >= TICK_W'(trigger_ticks_ff)) begin
               phase_in      = PH_WAIT;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + TICK_W'(1);
            end
         end
         PH_WAIT: begin
            if (in_echo_ff && !prev_echo_ff) begin
               phase_in      = PH_MEAS;
               tick_count_in = TICK_W'(1);
            end else if (tick_count_ff >= max_wait_ticks_ff) begin
               finish         = 1'b1;
               finish_timeout = 1'b1;
               finish_len     = clamp_ticks_ff;
            end else begin
               tick_count_in = tick_count_ff + TICK_W'(1);
            end
         end
         PH_MEAS: begin
            if (!in_echo_ff) begin
               finish     = 1'b1;
               finish_len = (tick_count_ff > clamp_ticks_ff) ? clamp_ticks_ff
                                                             : tick_count_ff;
            end else if (tick_count_ff != TICK_MAX) begin
               tick_count_in = tick_count_ff + TICK_W'(1);
            end
         end
         default: ;
      endcase
      if (finish) begin
         phase_in      = PH_IDLE;
         tick_count_in = '0;
      end
   end

   // Divide (len*16 + 29) by 58 through the reciprocal
   assign div_in   = {1'b0, finish_len, 4'b0000} + ROUND_ADD;
   assign div_prod = PROD_W'(div_in) * PROD_W'(RECIP);

   // Held result fields
   always_comb begin
      held_ticks_in   = held_ticks_ff;
      held_dist_in    = held_dist_ff;
      held_timeout_in = held_timeout_ff;
      if (finish) begin
         held_ticks_in   = finish_len;
         held_dist_in    = div_prod[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
         held_timeout_in = finish_timeout;
      end
   end

   always_comb begin
      rsp_flags_in.trigger   = (phase_in == PH_TRIG);
      rsp_flags_in.busy      = (phase_in != PH_IDLE);
      rsp_flags_in.done      = finish;
      rsp_flags_in.timed_out = held_timeout_in;
   end

   // Advance state and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= '0;
         prev_echo_ff    <= 1'b0;
         held_ticks_ff   <= '0;
         held_dist_ff    <= '0;
         held_timeout_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff        <= phase_in;
            tick_count_ff   <= tick_count_in;
            prev_echo_ff    <= in_echo_ff;
            held_ticks_ff   <= held_ticks_in;
            held_dist_ff    <= held_dist_in;
            held_timeout_ff <= held_timeout_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_flags_ff <= rsp_flags_in;
         rsp_ticks_ff <= held_ticks_in;
         rsp_dist_ff  <= held_dist_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_dist_ff, rsp_ticks_ff, rsp_flags_ff.timed_out,
                        rsp_flags_ff.done, rsp_flags_ff.busy, rsp_flags_ff.trigger};

   // Checks
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.done) |-> !rsp_flags_ff.busy)
      else $error("done pulse reported while still busy");

   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.trigger) |-> rsp_flags_ff.busy)
      else $error("trigger driven outside a measurement");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_count_ff == '0))
      else $error("tick counter not cleared in idle");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled tick dropped from request register");

endmodule

@@ dv/tb_ultrasonic_echo_ranger_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ultrasonic_echo_ranger_core: directed and random tick
// streams checked against a tick-level ranger model. Depends on uer_pkg and the core.
module tb_ultrasonic_echo_ranger_core;
   import uer_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 6;

   typedef enum logic [1:0] {
      RNG_IDLE,
      RNG_TRIGGER,
      RNG_LISTEN,
      RNG_TIMING
   } ranger_phase_type;

   typedef struct packed {
      logic              trigger;
      logic              busy;
      logic              done;
      logic              timed_out;
      logic [TICK_W-1:0] echo_ticks;
      logic [DIST_W-1:0] distance;
   } ranger_sample_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Ranger model state and its copy of the registers
   ranger_phase_type  m_phase       = RNG_IDLE;
   logic [TICK_W-1:0] m_count       = '0;
   logic              m_prev_echo   = 1'b0;
   logic [TICK_W-1:0] m_echo_ticks  = '0;
   logic [DIST_W-1:0] m_distance    = '0;
   logic              m_timed_out   = 1'b0;
   logic [TRIG_W-1:0] m_trigger_len = TRIGGER_TICKS_RST;
   logic [TICK_W-1:0] m_wait_limit  = MAX_WAIT_TICKS_RST;
   logic [TICK_W-1:0] m_clamp       = CLAMP_TICKS_RST;

   ranger_sample_type pending_samples[$];
   int             error_count   = 0;
   int             ticks_sent    = 0;
   int             cycle_count   = 0;
   int             send_idle_pct = 0;
   int             stall_pct     = 0;
   int             hold_request  = 0;
   int             hold_left     = 0;

   ultrasonic_echo_ranger_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Latch a finished measurement and return to idle
   function automatic void hold_result(input logic [TICK_W-1:0] len, input logic to);
      int unsigned q;
      q = 32'(len);
      q = (q * 16 + 29) / 58;
      m_echo_ticks = len;
      m_distance   = q[DIST_W-1:0];
      m_timed_out  = to;
      m_phase      = RNG_IDLE;
      m_count      = '0;
   endfunction

   // Advance the ranger by one tick and return the response it shows afterwards
   function automatic ranger_sample_type step_ranger(input logic start, input logic echo);
      ranger_sample_type s;
      logic              done_now;
      done_now = 1'b0;
      case (m_phase)
         RNG_IDLE: begin
            if (start) begin
               m_phase = RNG_TRIGGER;
               m_count = TICK_W'(1);
            end
         end
         RNG_TRIGGER: begin
            if (m_count >= m_trigger_len) begin
               m_phase = RNG_LISTEN;
               m_count = '0;
            end else begin
               m_count++;
            end
         end
         RNG_LISTEN: begin
            // only a low-to-high transition counts as the echo rise
            if (echo && !m_prev_echo) begin
               m_phase = RNG_TIMING;
               m_count = TICK_W'(1);
            end else if (m_count >= m_wait_limit) begin
               hold_result(m_clamp, 1'b1);
               done_now = 1'b1;
            end else begin
               m_count++;
            end
         end
         default: begin
            if (!echo) begin
               hold_result((m_count > m_clamp) ? m_clamp : m_count, 1'b0);
               done_now = 1'b1;
            end else if (m_count != TICK_MAX) begin
               m_count++;
            end
         end
      endcase
      m_prev_echo = echo;
      s.trigger    = (m_phase == RNG_TRIGGER);
      s.busy       = (m_phase != RNG_IDLE);
      s.done       = done_now;
      s.timed_out  = m_timed_out;
      s.echo_ticks = m_echo_ticks;
      s.distance   = m_distance;
      return s;
   endfunction

   function automatic void check_field(input string label, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Offer one tick; valid stays high into the next call unless it idles first
   task automatic send_tick(input logic start, input logic echo);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, echo};
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_samples.push_back(step_ranger(start, echo));
      ticks_sent++;
   endtask

   task automatic send_run(input logic start, input logic echo, input int count);
      repeat (count) send_tick(start, echo);
   endtask

   // Feed plain low ticks until the measurement in progress has ended
   task automatic finish_measurement();
      while (m_phase != RNG_IDLE) send_tick(1'b0, 1'b0);
   endtask

   // Drop valid, wait for every expected response, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TRIGGER_TICKS:  m_trigger_len = value[TRIG_W-1:0];
         CSR_MAX_WAIT_TICKS: m_wait_limit  = value;
         CSR_CLAMP_TICKS:    m_clamp       = value;
         default: ;
      endcase
   endtask

   task automatic configure(input int trig, input int wait_lim, input int clamp);
      write_reg(CSR_TRIGGER_TICKS, CSR_DATA_W'(trig));
      write_reg(CSR_MAX_WAIT_TICKS, CSR_DATA_W'(wait_lim));
      write_reg(CSR_CLAMP_TICKS, CSR_DATA_W'(clamp));
   endtask

   // Reset register values: one normal echo of 58 ticks
   task automatic test_default_ranging();
      send_run(1'b0, 1'b0, 2);
      send_tick(1'b1, 1'b0);
      send_run(1'b0, 1'b0, 14);
      send_run(1'b0, 1'b1, 58);
      send_tick(1'b0, 1'b0);
      finish_measurement();
   endtask

   // Start requests in every busy phase must be ignored
   task automatic test_busy_start_ignored();
      configure(3, 20, 100);
      send_tick(1'b1, 1'b0);
      send_run(1'b1, 1'b0, 7);
      send_run(1'b1, 1'b1, 6);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      finish_measurement();
   endtask

   // Echo already high when listening starts: no rise until it drops and returns
   task automatic test_echo_high_after_trigger();
      configure(2, 8, 100);
      send_tick(1'b1, 1'b1);
      send_run(1'b0, 1'b1, 14);
      send_tick(1'b1, 1'b1);
      send_run(1'b0, 1'b1, 3);
      send_run(1'b0, 1'b0, 2);
      send_run(1'b0, 1'b1, 5);
      send_tick(1'b0, 1'b0);
      finish_measurement();
   endtask

   // All registers zero: one-tick trigger, instant timeout, zero length
   task automatic test_zero_registers();
      configure(0, 0, 0);
      send_tick(1'b1, 1'b0);
      send_run(1'b0, 1'b0, 3);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_run(1'b0, 1'b1, 4);
      send_tick(1'b0, 1'b0);
      finish_measurement();
   endtask

   // Long trigger with an echo that runs past the clamp
   task automatic test_clamp_and_saturation();
      configure(20, 30, 10);
      send_tick(1'b1, 1'b0);
      send_run(1'b0, 1'b0, 25);
      send_run(1'b0, 1'b1, 15);
      send_tick(1'b0, 1'b0);
      finish_measurement();
   endtask

   // Timeout with the largest clamp: reports the largest length and distance
   task automatic test_timeout_full_clamp();
      configure(1, 5, 65535);
      send_tick(1'b1, 1'b0);
      finish_measurement();
   endtask

   // Mostly well-formed measurements with random content, some noise between
   task automatic test_random_ranging(input int idle_pct, input int stall, input int count);
      int first_tick;
      int trig;
      int wait_lim;
      int clamp;
      trig     = $urandom_range(0, 4);
      wait_lim = $urandom_range(0, 24);
      clamp    = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 40);
      configure(trig, wait_lim, clamp);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      first_tick    = ticks_sent;
      while (ticks_sent - first_tick < count) begin
         if ($urandom_range(99) < 85) begin
            finish_measurement();
            send_tick(1'b1, 1'($urandom_range(1)));
            repeat (trig + 1) send_tick($urandom_range(99) < 20, $urandom_range(99) < 10);
            repeat ($urandom_range(0, wait_lim + 3)) send_tick($urandom_range(99) < 20, 1'b0);
            repeat ($urandom_range(1, clamp + 4)) send_tick($urandom_range(99) < 20, 1'b1);
            repeat ($urandom_range(1, 3)) send_tick($urandom_range(99) < 20, 1'b0);
         end else begin
            repeat ($urandom_range(1, 8))
               send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
      finish_measurement();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // Receiver holds off for a long stretch while ticks keep coming
   task automatic test_output_backpressure();
      configure(2, 10, 30);
      hold_request = 300;
      repeat (3) begin
         send_tick(1'b1, 1'b0);
         send_run(1'b0, 1'b0, 5);
         send_run(1'b0, 1'b1, $urandom_range(1, 20));
         send_tick(1'b0, 1'b0);
      end
      finish_measurement();
   endtask

   // Response side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each response transfer with the oldest expected sample
   always @(posedge clock) begin : check_rsp
      ranger_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: response with none expected, expected none, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            // tdata: trigger, busy, done, timed_out, echo_ticks, distance from bit 0 up
            check_field("trigger_level", 32'(want.trigger), 32'(rsp_tdata[0]));
            check_field("busy_res", 32'(want.busy), 32'(rsp_tdata[1]));
            check_field("done_res", 32'(want.done), 32'(rsp_tdata[2]));
            check_field("timed_out", 32'(want.timed_out), 32'(rsp_tdata[3]));
            check_field("echo_ticks", 32'(want.echo_ticks), 32'(rsp_tdata[19:4]));
            check_field("distance_sixteenths", 32'(want.distance),
                        32'(rsp_tdata[34:20]));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int send_plan[4];
      int stall_plan[4];
      send_plan  = '{0, 82, 0, 18};
      stall_plan = '{0, 0, 82, 18};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_ranging();
      test_busy_start_ignored();
      test_echo_high_after_trigger();
      test_zero_registers();
      test_clamp_and_saturation();
      test_timeout_full_clamp();
      for (int i = 0; i < 4; i++) begin
         test_random_ranging(send_plan[i], stall_plan[i], 30);
      end
      test_output_backpressure();
      settle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
